// ===== rtl/ptne_pkg.sv =====
// Shared types, constants and the volume table of the tone/noise/envelope generator.
package ptne_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_IGNORE   = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_TICK_ENV = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  addr;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] level_a;
		logic [7:0] level_b;
		logic [7:0] level_c;
		logic [3:0] envelope_level;
	} res_t;

	// register map
	localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
	localparam logic [3:0] REG_MIXER        = 4'd7;
	localparam logic [3:0] REG_VOLUME_A     = 4'd8;
	localparam logic [3:0] REG_ENV_FINE     = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

	localparam logic [7:0]  MIXER_RESET       = 8'hFF;
	localparam logic [12:0] TONE_ZERO_PERIOD  = 13'h1000;
	localparam logic [5:0]  NOISE_ZERO_PERIOD = 6'h20;
	localparam logic [15:0] ENV_ZERO_PERIOD   = 16'h1000;
	localparam logic [16:0] NOISE_SEED        = 17'h0AAAA;
	localparam logic [16:0] NOISE_TAPS        = 17'h14000;

	localparam logic [3:0] ENV_TOP = 4'd15;
	localparam logic [3:0] ENV_BOTTOM = 4'd0;
	localparam logic [3:0] ENV_NEAR_TOP = 4'd14;
	localparam logic [3:0] ENV_NEAR_BOTTOM = 4'd1;

	// shape register bits
	localparam int SHAPE_HOLD      = 0;
	localparam int SHAPE_ALTERNATE = 1;
	localparam int SHAPE_ATTACK    = 2;
	localparam int SHAPE_CONTINUE  = 3;

	function automatic logic [7:0] vol_lookup(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:  v = 8'd0;
			4'd1:  v = 8'd2;
			4'd2:  v = 8'd5;
			4'd3:  v = 8'd7;
			4'd4:  v = 8'd10;
			4'd5:  v = 8'd14;
			4'd6:  v = 8'd19;
			4'd7:  v = 8'd29;
			4'd8:  v = 8'd40;
			4'd9:  v = 8'd56;
			4'd10: v = 8'd80;
			4'd11: v = 8'd103;
			4'd12: v = 8'd131;
			4'd13: v = 8'd161;
			4'd14: v = 8'd197;
			4'd15: v = 8'd236;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/psg_tone_noise_envelope_generator_top.sv =====
// Top level of the three-channel tone/noise/envelope sound generator.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// An item is either a register write (op = 0, reg_addr, reg_data) or one tick
// (op = 1, envelope_step also clocks the envelope divider).
// Result channel: while empty is low the oldest result (level_a/b/c and
// envelope_level) is on the ports; it is taken at an edge with pop high.
// Every item gives exactly one result; a write repeats the held levels.
// The back end works combinationally on the head of the command queue and
// writes the result queue at the same edge that takes the command, so a result
// goes through both queues before it can be popped. Throughput is one item per
// cycle while the receiver keeps popping and the result queue is not full.
// When the receiver stalls, the result queue fills, the back end stops, then
// the command queue fills and full rises; nothing is lost.
// Reset (arst_n low) empties both queues, clears all dividers, the noise shift
// register and the envelope, and loads the register file with zeros except the
// mixer register, which reads all ones (every tone and noise source off).
module psg_tone_noise_envelope_generator_top #(
	parameter int REGISTER_COUNT = 16,
	parameter int QUEUE_DEPTH    = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       op,
	input  logic [3:0] reg_addr,
	input  logic [7:0] reg_data,
	input  logic       envelope_step,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] level_a,
	output logic [7:0] level_b,
	output logic [7:0] level_c,
	output logic [3:0] envelope_level
);

	localparam int CMD_W = $bits(ptne_pkg::cmd_t);
	localparam int RES_W = $bits(ptne_pkg::res_t);

	ptne_pkg::cmd_t in_cmd;
	ptne_pkg::cmd_t q_cmd;
	ptne_pkg::res_t eng_res;
	ptne_pkg::res_t out_res;
	logic [CMD_W-1:0] q_cmd_bits;
	logic [RES_W-1:0] out_res_bits;
	logic cmd_push;
	logic cmd_empty;
	logic cmd_pop;
	logic res_push;
	logic res_full;

	ptne_front #(.REGISTER_COUNT(REGISTER_COUNT)) u_front (
		.push          (push),
		.q_full        (full),
		.op            (op),
		.reg_addr      (reg_addr),
		.reg_data      (reg_data),
		.envelope_step (envelope_step),
		.cmd_push      (cmd_push),
		.cmd           (in_cmd)
	);

	ptne_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (in_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (q_cmd_bits),
		.empty  (cmd_empty)
	);

	assign q_cmd = ptne_pkg::cmd_t'(q_cmd_bits);

	ptne_engine #(.REGISTER_COUNT(REGISTER_COUNT)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (eng_res)
	);

	ptne_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (eng_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res_bits),
		.empty  (empty)
	);

	assign out_res        = ptne_pkg::res_t'(out_res_bits);
	assign level_a        = out_res.level_a;
	assign level_b        = out_res.level_b;
	assign level_c        = out_res.level_c;
	assign envelope_level = out_res.envelope_level;

	// back end never writes into a full result queue
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result written while result queue full");

	// back end only consumes a command that is there
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> !cmd_empty)
		else $error("command taken from empty queue");

	// one result per command executed
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop == res_push)
		else $error("command and result counts diverge");

	// a stalled back end leaves the command queue untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_full && !pop && !cmd_empty) |=> !cmd_empty)
		else $error("command lost while back end stalled");

endmodule

// ===== rtl/ptne_fifo.sv =====
// Small first-in first-out queue of flip-flops, used for commands and for results.
module ptne_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/ptne_front.sv =====
// Front end: takes items from the input port and sorts them into commands.
module ptne_front #(
	parameter int REGISTER_COUNT = 16
) (
	input  logic             push,
	input  logic             q_full,
	input  logic             op,
	input  logic [3:0]       reg_addr,
	input  logic [7:0]       reg_data,
	input  logic             envelope_step,
	output logic             cmd_push,
	output ptne_pkg::cmd_t   cmd
);

	logic addr_ok;

	assign addr_ok  = (5'({1'b0, reg_addr}) < 5'(REGISTER_COUNT));
	assign cmd_push = push && !q_full;

	always_comb begin
		cmd.addr = reg_addr;
		cmd.data = reg_data;
		if (op) begin
			cmd.kind = envelope_step ? ptne_pkg::CMD_TICK_ENV : ptne_pkg::CMD_TICK;
		end else begin
			// writes past the register file are dropped but still give a result
			cmd.kind = addr_ok ? ptne_pkg::CMD_WRITE : ptne_pkg::CMD_IGNORE;
		end
	end

endmodule

// ===== rtl/ptne_engine.sv =====
// Back end: register file, tone/noise/envelope dividers and channel mixing.
module ptne_engine #(
	parameter int REGISTER_COUNT = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ptne_pkg::cmd_t   cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output ptne_pkg::res_t   res
);

	localparam int RIDX_W = $clog2(REGISTER_COUNT);

	logic [7:0]  regs_q [REGISTER_COUNT];
	logic [12:0] tone_cnt_q [3];
	logic [2:0]  tone_bit_q;
	logic [15:0] env_cnt_q;
	logic [3:0]  env_step_q;
	logic        env_stop_q;
	logic        env_rev_q;
	logic [16:0] noise_q;
	logic [5:0]  noise_cnt_q;
	logic [7:0]  level_q [3];

	logic        fire;
	logic        is_tick;
	logic        env_go;

	// envelope
	logic [7:0]  shape;
	logic [15:0] env_period;
	logic [15:0] env_cnt_inc;
	logic        env_expire;
	logic        rising;
	logic        at_end;
	logic [15:0] env_cnt_d;
	logic [3:0]  env_step_d;
	logic        env_stop_d;
	logic        env_rev_d;

	// noise
	logic [5:0]  noise_period;
	logic [5:0]  noise_cnt_inc;
	logic        noise_expire;
	logic [16:0] noise_seeded;
	logic [16:0] noise_d;
	logic [5:0]  noise_cnt_d;

	// tone and mixing
	logic [12:0] tone_cnt_d [3];
	logic [2:0]  tone_bit_d;
	logic [7:0]  level_d [3];

	assign fire     = cmd_valid && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign is_tick  = (cmd.kind == ptne_pkg::CMD_TICK) || (cmd.kind == ptne_pkg::CMD_TICK_ENV);
	assign env_go   = (cmd.kind == ptne_pkg::CMD_TICK_ENV);

	// ---------------- envelope ----------------
	assign shape       = regs_q[ptne_pkg::REG_ENV_SHAPE];
	assign env_period  = ({regs_q[ptne_pkg::REG_ENV_COARSE], regs_q[ptne_pkg::REG_ENV_FINE]} == '0)
		? ptne_pkg::ENV_ZERO_PERIOD
		: {regs_q[ptne_pkg::REG_ENV_COARSE], regs_q[ptne_pkg::REG_ENV_FINE]};
	assign env_cnt_inc = env_cnt_q + 16'd1;
	assign env_expire  = !((env_cnt_inc < env_period) && (env_cnt_inc != '0));
	assign rising      = env_rev_q ^ shape[ptne_pkg::SHAPE_ATTACK];
	assign at_end      = rising ? (env_step_q == ptne_pkg::ENV_TOP) : (env_step_q == ptne_pkg::ENV_BOTTOM);

	always_comb begin
		env_cnt_d  = env_cnt_q;
		env_step_d = env_step_q;
		env_stop_d = env_stop_q;
		env_rev_d  = env_rev_q;
		if (env_go) begin
			if (!env_expire) begin
				env_cnt_d = env_cnt_inc;
			end else begin
				env_cnt_d = '0;
				if (!env_stop_q) begin
					if (!at_end) begin
						env_step_d = rising ? env_step_q + 4'd1 : env_step_q - 4'd1;
					end else if (!shape[ptne_pkg::SHAPE_CONTINUE]) begin
						env_step_d = ptne_pkg::ENV_BOTTOM;
						env_stop_d = 1'b1;
					end else if (env_rev_q) begin
						// wrap while reversed undoes the reversal
						env_rev_d  = 1'b0;
						env_step_d = rising ? ptne_pkg::ENV_NEAR_TOP : ptne_pkg::ENV_NEAR_BOTTOM;
					end else if (shape[ptne_pkg::SHAPE_HOLD]) begin
						env_step_d = (rising ^ shape[ptne_pkg::SHAPE_ALTERNATE])
							? ptne_pkg::ENV_TOP : ptne_pkg::ENV_BOTTOM;
						env_stop_d = 1'b1;
					end else if (shape[ptne_pkg::SHAPE_ALTERNATE]) begin
						env_rev_d  = 1'b1;
						env_step_d = rising ? ptne_pkg::ENV_NEAR_TOP : ptne_pkg::ENV_NEAR_BOTTOM;
					end else begin
						env_step_d = rising ? ptne_pkg::ENV_BOTTOM : ptne_pkg::ENV_TOP;
					end
				end
			end
		end
	end

	// ---------------- noise ----------------
	assign noise_period  = (regs_q[ptne_pkg::REG_NOISE_PERIOD][4:0] == '0)
		? ptne_pkg::NOISE_ZERO_PERIOD
		: {1'b0, regs_q[ptne_pkg::REG_NOISE_PERIOD][4:0]};
	assign noise_cnt_inc = noise_cnt_q + 6'd1;
	assign noise_expire  = (noise_cnt_inc >= noise_period) || (noise_cnt_inc == '0);
	assign noise_seeded  = (noise_q == '0) ? ptne_pkg::NOISE_SEED : noise_q;

	always_comb begin
		noise_d     = noise_q;
		noise_cnt_d = noise_cnt_q;
		if (is_tick) begin
			if (noise_expire) begin
				noise_cnt_d = '0;
				noise_d = (noise_seeded >> 1) ^ (noise_seeded[0] ? ptne_pkg::NOISE_TAPS : '0);
			end else begin
				noise_cnt_d = noise_cnt_inc;
			end
		end
	end

	// ---------------- tone dividers and mixer, one lane per channel ----------------
	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [12:0] period;
		logic [12:0] cnt_inc;
		logic        expire;
		logic [7:0]  vreg;
		logic [7:0]  vol;
		logic [7:0]  tone_part;
		logic [7:0]  noise_part;

		assign period  = ({regs_q[2*c+1][3:0], regs_q[2*c]} == '0)
			? ptne_pkg::TONE_ZERO_PERIOD
			: {1'b0, regs_q[2*c+1][3:0], regs_q[2*c]};
		assign cnt_inc = tone_cnt_q[c] + 13'd1;
		assign expire  = (cnt_inc >= period) || (cnt_inc == '0);

		assign tone_cnt_d[c] = !is_tick ? tone_cnt_q[c] : (expire ? '0 : cnt_inc);
		assign tone_bit_d[c] = tone_bit_q[c] ^ (is_tick && expire);

		assign vreg = regs_q[int'(ptne_pkg::REG_VOLUME_A) + c];
		assign vol  = ptne_pkg::vol_lookup(vreg[4] ? env_step_d : vreg[3:0]);

		// three quarters on a high tone, one quarter on a set noise bit
		assign tone_part  = (!regs_q[ptne_pkg::REG_MIXER][c] && tone_bit_d[c])
			? (vol >> 1) + (vol >> 2) : '0;
		assign noise_part = (noise_d[0] && !regs_q[ptne_pkg::REG_MIXER][3+c]) ? (vol >> 2) : '0;

		assign level_d[c] = is_tick ? tone_part + noise_part : level_q[c];
	end

	assign res.level_a        = level_d[0];
	assign res.level_b        = level_d[1];
	assign res.level_c        = level_d[2];
	assign res.envelope_level = env_step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				regs_q[i] <= (i == int'(ptne_pkg::REG_MIXER)) ? ptne_pkg::MIXER_RESET : '0;
			end
			for (int i = 0; i < 3; i++) begin
				tone_cnt_q[i] <= '0;
				level_q[i]    <= '0;
			end
			tone_bit_q  <= '0;
			env_cnt_q   <= '0;
			env_step_q  <= '0;
			env_stop_q  <= 1'b0;
			env_rev_q   <= 1'b0;
			noise_q     <= '0;
			noise_cnt_q <= '0;
		end else if (fire) begin
			if (cmd.kind == ptne_pkg::CMD_WRITE) begin
				regs_q[cmd.addr[RIDX_W-1:0]] <= cmd.data;
			end
			for (int i = 0; i < 3; i++) begin
				tone_cnt_q[i] <= tone_cnt_d[i];
				level_q[i]    <= level_d[i];
			end
			tone_bit_q  <= tone_bit_d;
			env_cnt_q   <= env_cnt_d;
			env_step_q  <= env_step_d;
			env_stop_q  <= env_stop_d;
			env_rev_q   <= env_rev_d;
			noise_q     <= noise_d;
			noise_cnt_q <= noise_cnt_d;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the tone/noise/envelope sound generator: directed and random items.
module testbench;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
	localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
	localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
	localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
	localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
	localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
	localparam logic [3:0] REG_VOLUME_B      = 4'd9;
	localparam logic [3:0] REG_VOLUME_C      = 4'd10;

	localparam logic [7:0] VOL_STEPS [16] = '{
		8'd0, 8'd2, 8'd5, 8'd7, 8'd10, 8'd14, 8'd19, 8'd29,
		8'd40, 8'd56, 8'd80, 8'd103, 8'd131, 8'd161, 8'd197, 8'd236
	};

	localparam int PHASES = 4;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int DRAIN_CYCLES = 4;

	// Mirrors the generator state and keeps the levels still owed by the block.
	class psg_level_tracker;
		logic [7:0]      regs [16];
		logic [12:0]     tone_cnt [3];
		logic            tone_bit [3];
		logic [15:0]     env_cnt;
		logic [4:0]      env_val;
		logic            env_stopped;
		logic            env_reversed;
		logic [16:0]     noise_lfsr;
		logic [5:0]      noise_cnt;
		logic [7:0]      levels [3];
		ptne_pkg::res_t  pending_levels [$];
		int              mismatches;
		int              checked;

		function new();
			foreach (regs[i])
				regs[i] = 8'h00;
			regs[ptne_pkg::REG_MIXER] = ptne_pkg::MIXER_RESET;
			for (int ch = 0; ch < 3; ch++) begin
				tone_cnt[ch] = '0;
				tone_bit[ch] = 1'b0;
				levels[ch]   = '0;
			end
			env_cnt      = '0;
			env_val      = '0;
			env_stopped  = 1'b0;
			env_reversed = 1'b0;
			noise_lfsr   = '0;
			noise_cnt    = '0;
			mismatches   = 0;
			checked      = 0;
		endfunction

		function void envelope_wrap(bit rising);
			logic [7:0] shape;
			shape = regs[ptne_pkg::REG_ENV_SHAPE];
			if (!shape[ptne_pkg::SHAPE_CONTINUE]) begin
				env_val     = ptne_pkg::ENV_BOTTOM;
				env_stopped = 1'b1;
			end else if (env_reversed) begin
				// second half of an alternating cycle ends: back to the normal direction
				env_reversed = 1'b0;
				env_val      = rising ? ptne_pkg::ENV_NEAR_TOP : ptne_pkg::ENV_NEAR_BOTTOM;
			end else if (shape[ptne_pkg::SHAPE_HOLD]) begin
				env_val     = (rising ^ shape[ptne_pkg::SHAPE_ALTERNATE])
					? ptne_pkg::ENV_TOP : ptne_pkg::ENV_BOTTOM;
				env_stopped = 1'b1;
			end else if (shape[ptne_pkg::SHAPE_ALTERNATE]) begin
				env_reversed = 1'b1;
				env_val      = rising ? ptne_pkg::ENV_NEAR_TOP : ptne_pkg::ENV_NEAR_BOTTOM;
			end else begin
				env_val = rising ? ptne_pkg::ENV_BOTTOM : ptne_pkg::ENV_TOP;
			end
		endfunction

		function void note_item(logic op, logic [3:0] addr, logic [7:0] data, logic env_step);
			logic [15:0]    env_period;
			logic [5:0]     noise_period;
			logic [12:0]    tone_period;
			logic [7:0]     vreg;
			logic [7:0]     vol;
			logic [8:0]     lvl;
			bit             rising;
			ptne_pkg::res_t exp_levels;

			if (op == OP_WRITE) begin
				regs[addr] = data;
			end else begin
				if (env_step) begin
					env_period = {regs[ptne_pkg::REG_ENV_COARSE], regs[ptne_pkg::REG_ENV_FINE]};
					if (env_period == 0)
						env_period = ptne_pkg::ENV_ZERO_PERIOD;
					env_cnt = env_cnt + 16'd1;
					if (env_cnt >= env_period || env_cnt == 0) begin
						env_cnt = '0;
						if (!env_stopped) begin
							rising = env_reversed ^
								regs[ptne_pkg::REG_ENV_SHAPE][ptne_pkg::SHAPE_ATTACK];
							if (rising) begin
								if (env_val >= 5'(ptne_pkg::ENV_TOP))
									envelope_wrap(1'b1);
								else
									env_val = env_val + 5'd1;
							end else if (env_val == 0) begin
								envelope_wrap(1'b0);
							end else begin
								env_val = env_val - 5'd1;
							end
						end
					end
				end

				noise_period = {1'b0, regs[ptne_pkg::REG_NOISE_PERIOD][4:0]};
				if (noise_period == 0)
					noise_period = ptne_pkg::NOISE_ZERO_PERIOD;
				noise_cnt = noise_cnt + 6'd1;
				if (noise_cnt >= noise_period || noise_cnt == 0) begin
					noise_cnt = '0;
					if (noise_lfsr == 0)
						noise_lfsr = ptne_pkg::NOISE_SEED;
					noise_lfsr = (noise_lfsr >> 1) ^
						(noise_lfsr[0] ? ptne_pkg::NOISE_TAPS : 17'd0);
				end

				for (int ch = 0; ch < 3; ch++) begin
					tone_period = {1'b0, regs[2 * ch + 1][3:0], regs[2 * ch]};
					if (tone_period == 0)
						tone_period = ptne_pkg::TONE_ZERO_PERIOD;
					tone_cnt[ch] = tone_cnt[ch] + 13'd1;
					if (tone_cnt[ch] >= tone_period || tone_cnt[ch] == 0) begin
						tone_bit[ch] = ~tone_bit[ch];
						tone_cnt[ch] = '0;
					end
					vreg = regs[ptne_pkg::REG_VOLUME_A + ch];
					vol  = VOL_STEPS[vreg[4] ? env_val[3:0] : vreg[3:0]];
					// tone gives 3/4 of the volume, noise the remaining quarter
					lvl = '0;
					if (!regs[ptne_pkg::REG_MIXER][ch] && tone_bit[ch])
						lvl = 9'(vol >> 1) + 9'(vol >> 2);
					if (noise_lfsr[0] && !regs[ptne_pkg::REG_MIXER][3 + ch])
						lvl = lvl + 9'(vol >> 2);
					levels[ch] = lvl[7:0];
				end
			end

			exp_levels.level_a        = levels[0];
			exp_levels.level_b        = levels[1];
			exp_levels.level_c        = levels[2];
			exp_levels.envelope_level = env_val[3:0];
			pending_levels.push_back(exp_levels);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_levels(ptne_pkg::res_t got);
			ptne_pkg::res_t exp_levels;
			if (pending_levels.size() == 0) begin
				$error("result with no item waiting for it");
				mismatches++;
				return;
			end
			exp_levels = pending_levels.pop_front();
			checked++;
			compare_field("level_a", exp_levels.level_a, got.level_a);
			compare_field("level_b", exp_levels.level_b, got.level_b);
			compare_field("level_c", exp_levels.level_c, got.level_c);
			compare_field("envelope_level", exp_levels.envelope_level, got.envelope_level);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       op;
	logic [3:0] reg_addr;
	logic [7:0] reg_data;
	logic       envelope_step;
	logic       pop;
	logic       empty;
	logic [7:0] level_a;
	logic [7:0] level_b;
	logic [7:0] level_c;
	logic [3:0] envelope_level;

	psg_level_tracker level_tracker = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int writes_sent = 0;
	int ticks_sent = 0;

	psg_tone_noise_envelope_generator_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.op             (op),
		.reg_addr       (reg_addr),
		.reg_data       (reg_data),
		.envelope_step  (envelope_step),
		.pop            (pop),
		.empty          (empty),
		.level_a        (level_a),
		.level_b        (level_b),
		.level_c        (level_c),
		.envelope_level (envelope_level)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 500000);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: pop stalls at the current phase's rate
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				level_tracker.note_item(op, reg_addr, reg_data, envelope_step);
				if (op == OP_WRITE)
					writes_sent++;
				else
					ticks_sent++;
			end
			if (pop && !empty)
				level_tracker.check_levels({level_a, level_b, level_c, envelope_level});
		end
	end

	task automatic send_item(logic o, logic [3:0] a, logic [7:0] d, logic e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		op            <= o;
		reg_addr      <= a;
		reg_data      <= d;
		envelope_step <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] a, logic [7:0] d);
		send_item(OP_WRITE, a, d, 1'($urandom_range(0, 1)));
	endtask

	// address and data bits are don't-care on a tick, so they carry noise
	task automatic tick(logic e);
		send_item(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), e);
	endtask

	task automatic random_item(bit allow_stop);
		logic [3:0] a;
		logic [7:0] d;
		bit         shrink;
		if ($urandom_range(0, 3) != 0) begin
			tick($urandom_range(0, 9) < 7);
		end else begin
			a      = 4'($urandom_range(0, 15));
			d      = 8'($urandom_range(0, 255));
			shrink = 1'($urandom_range(0, 1));
			// short periods half of the time so the dividers keep expiring
			case (a)
				REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE,
				ptne_pkg::REG_ENV_FINE: begin
					if (shrink)
						d = 8'($urandom_range(0, 7));
				end
				REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: begin
					if (shrink)
						d = d & 8'hF0;
				end
				ptne_pkg::REG_ENV_COARSE: begin
					if (shrink)
						d = 8'h00;
				end
				ptne_pkg::REG_ENV_SHAPE: begin
					// a stopped envelope never restarts: keep it running until the last phase
					if (!allow_stop) begin
						d[ptne_pkg::SHAPE_CONTINUE] = 1'b1;
						d[ptne_pkg::SHAPE_HOLD]     = 1'b0;
					end
				end
				default: ;
			endcase
			write_reg(a, d);
		end
	endtask

	initial begin
		int send_idle_by_phase [PHASES];
		int recv_stall_by_phase [PHASES];
		int drain;

		send_idle_by_phase  = '{0, 72, 0, 14};
		recv_stall_by_phase = '{0, 0, 72, 14};

		arst_n        <= 1'b0;
		push          <= 1'b0;
		op            <= OP_WRITE;
		reg_addr      <= '0;
		reg_data      <= '0;
		envelope_step <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every source on, extreme periods and volumes, envelope on a short period
		write_reg(ptne_pkg::REG_MIXER, 8'h00);
		write_reg(REG_TONE_A_FINE, 8'h01);
		write_reg(REG_TONE_A_COARSE, 8'h00);
		write_reg(REG_TONE_B_FINE, 8'h00);
		write_reg(REG_TONE_B_COARSE, 8'h00);
		write_reg(REG_TONE_C_FINE, 8'hFF);
		write_reg(REG_TONE_C_COARSE, 8'hFF);
		write_reg(ptne_pkg::REG_NOISE_PERIOD, 8'h00);
		write_reg(ptne_pkg::REG_VOLUME_A, 8'h0F);
		write_reg(REG_VOLUME_B, 8'h1F);
		write_reg(REG_VOLUME_C, 8'hF0);
		write_reg(ptne_pkg::REG_ENV_FINE, 8'h01);
		write_reg(ptne_pkg::REG_ENV_COARSE, 8'h00);
		write_reg(ptne_pkg::REG_ENV_SHAPE, 8'h0E);
		for (int i = 0; i < 6; i++)
			tick(1'(i));
		// tone C period dropped under its running count
		write_reg(REG_TONE_C_FINE, 8'h02);
		write_reg(REG_TONE_C_COARSE, 8'h00);
		tick(1'b1);
		tick(1'b1);
		// shortest noise period: first shift loads the seed
		write_reg(ptne_pkg::REG_NOISE_PERIOD, 8'hE1);
		tick(1'b1);

		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct  = send_idle_by_phase[p];
			recv_stall_pct = recv_stall_by_phase[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_item(p == PHASES - 1);
		end
		push <= 1'b0;
		recv_stall_pct = 0;

		drain = 0;
		while (level_tracker.pending_levels.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d register writes and %0d ticks over four pacing phases;",
			writes_sent, ticks_sent);
		$display("%0d results checked, %0d mismatches, %0d still owed.",
			level_tracker.checked, level_tracker.mismatches,
			level_tracker.pending_levels.size());
		if (level_tracker.mismatches == 0 && level_tracker.pending_levels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
